[hw/rtl/pcbb_pkg.sv]
// ----------------------------------------------------------------------------
// pcbb_pkg
// Shared types and constants for the projection content bounding box.
// ----------------------------------------------------------------------------
package pcbb_pkg;

   // content thresholds: LOW_FACTOR*n < sum < HIGH_FACTOR*n
   localparam int LOW_FACTOR  = 51;
   localparam int HIGH_FACTOR = 255;

   localparam int PIXEL_W     = 8;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int BOX_FIELD_W = 10;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [CSR_DATA_W-1:0] FRAME_SIZE_RESET = 11'd1024;

   // control flags of the pixel held in the accumulate stage
   typedef struct packed {
      logic valid;
      logic first_row;   // first row of the frame: column sum is written, not added
      logic row_end;     // last pixel of its row
      logic last_row;    // pixel lies on the last row of the frame
      logic frame_end;   // last pixel of the frame
   } stage_ctl_type;

   // one result
   typedef struct packed {
      logic [BOX_FIELD_W-1:0] x;
      logic [BOX_FIELD_W-1:0] y;
      logic [BOX_FIELD_W-1:0] width;
      logic [BOX_FIELD_W-1:0] height;
      logic                   valid;
   } box_type;

endpackage

[hw/rtl/pcbb_ram.sv]
// ----------------------------------------------------------------------------
// pcbb_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module pcbb_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];   // old data on a same-address write
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pcbb_front.sv]
// ----------------------------------------------------------------------------
// pcbb_front
// Raster position counters, frame size clamp, column sum read and the
// pipeline register in front of the accumulate stage.
// ----------------------------------------------------------------------------
module pcbb_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int WW  = $clog2(MAX_WIDTH + 1),
   localparam int HW  = $clog2(MAX_HEIGHT + 1),
   localparam int CSW = $clog2(pcbb_pkg::HIGH_FACTOR * MAX_HEIGHT + 1),
   localparam int RSW = $clog2(pcbb_pkg::HIGH_FACTOR * MAX_WIDTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [pcbb_pkg::PIXEL_W-1:0]      req_pixel,
   output logic                              req_stall,
   input  logic [pcbb_pkg::CSR_DATA_W-1:0]   frame_width,
   input  logic [pcbb_pkg::CSR_DATA_W-1:0]   frame_height,
   input  logic                              out_busy,
   input  logic [CSW-1:0]                    csum,
   output logic                              rd_en,
   output logic [CW-1:0]                     rd_addr,
   output pcbb_pkg::stage_ctl_type           s1_ctl,
   output logic [pcbb_pkg::PIXEL_W-1:0]      s1_pixel,
   output logic [CW-1:0]                     s1_col,
   output logic [RW-1:0]                     s1_row,
   output logic [CSW-1:0]                    s1_col_lo,
   output logic [CSW-1:0]                    s1_col_hi,
   output logic [RSW-1:0]                    s1_row_lo,
   output logic [RSW-1:0]                    s1_row_hi,
   output logic                              s1_fwd,
   output logic [CSW-1:0]                    s1_fwd_data
);

   import pcbb_pkg::*;

   logic [CW-1:0]         col_pos_ff, col_pos_in;
   logic [RW-1:0]         row_pos_ff, row_pos_in;
   logic [WW-1:0]         w_clamp, col_next;
   logic [HW-1:0]         h_clamp, row_next;
   logic                  row_end, last_row, frame_end, accept;
   stage_ctl_type         ctl_ff, ctl_in;
   logic [PIXEL_W-1:0]    pixel_ff;
   logic [CW-1:0]         col_ff;
   logic [RW-1:0]         row_ff;
   logic [CSW-1:0]        col_lo_ff, col_hi_ff;
   logic [RSW-1:0]        row_lo_ff, row_hi_ff;
   logic                  fwd_ff, fwd_in;
   logic [CSW-1:0]        fwd_data_ff;

   // size 0 acts as 1, anything above the maximum as the maximum
   always_comb begin
      if (frame_width == '0) begin
         w_clamp = WW'(1);
      end else if (int'(frame_width) > MAX_WIDTH) begin
         w_clamp = WW'(MAX_WIDTH);
      end else begin
         w_clamp = WW'(frame_width);
      end
      if (frame_height == '0) begin
         h_clamp = HW'(1);
      end else if (int'(frame_height) > MAX_HEIGHT) begin
         h_clamp = HW'(MAX_HEIGHT);
      end else begin
         h_clamp = HW'(frame_height);
      end
   end

   assign col_next  = WW'(col_pos_ff) + WW'(1);
   assign row_next  = HW'(row_pos_ff) + HW'(1);
   assign row_end   = (col_next >= w_clamp);
   assign last_row  = (row_next >= h_clamp);
   assign frame_end = row_end && last_row;

   // a frame end may only enter when the output register is sure to be free
   assign req_stall = frame_end && ((ctl_ff.valid && ctl_ff.frame_end) || out_busy);
   assign accept    = req_valid && !req_stall;

   assign rd_en   = accept;
   assign rd_addr = col_pos_ff;

   // back-to-back hit on the column being written this cycle
   assign fwd_in = accept && ctl_ff.valid && (col_pos_ff == col_ff);

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (accept) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = last_row ? '0 : RW'(row_next);
         end else begin
            col_pos_in = CW'(col_next);
         end
      end
      ctl_in.valid     = accept;
      ctl_in.first_row = (row_pos_ff == '0);
      ctl_in.row_end   = row_end;
      ctl_in.last_row  = last_row;
      ctl_in.frame_end = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         ctl_ff     <= '0;
         fwd_ff     <= 1'b0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         ctl_ff     <= ctl_in;
         fwd_ff     <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff    <= req_pixel;
         col_ff      <= col_pos_ff;
         row_ff      <= row_pos_ff;
         col_lo_ff   <= CSW'(h_clamp) * CSW'(LOW_FACTOR);
         col_hi_ff   <= CSW'(h_clamp) * CSW'(HIGH_FACTOR);
         row_lo_ff   <= RSW'(w_clamp) * RSW'(LOW_FACTOR);
         row_hi_ff   <= RSW'(w_clamp) * RSW'(HIGH_FACTOR);
         fwd_data_ff <= csum;
      end
   end

   assign s1_ctl      = ctl_ff;
   assign s1_pixel    = pixel_ff;
   assign s1_col      = col_ff;
   assign s1_row      = row_ff;
   assign s1_col_lo   = col_lo_ff;
   assign s1_col_hi   = col_hi_ff;
   assign s1_row_lo   = row_lo_ff;
   assign s1_row_hi   = row_hi_ff;
   assign s1_fwd      = fwd_ff;
   assign s1_fwd_data = fwd_data_ff;

endmodule

[hw/rtl/pcbb_accum.sv]
// ----------------------------------------------------------------------------
// pcbb_accum
// Column sum read-modify-write, row sum, content tests and bound tracking.
// Builds the box on the last pixel of the frame and clears frame state.
// ----------------------------------------------------------------------------
module pcbb_accum #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int CSW = $clog2(pcbb_pkg::HIGH_FACTOR * MAX_HEIGHT + 1),
   localparam int RSW = $clog2(pcbb_pkg::HIGH_FACTOR * MAX_WIDTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pcbb_pkg::stage_ctl_type        s1_ctl,
   input  logic [pcbb_pkg::PIXEL_W-1:0]   s1_pixel,
   input  logic [CW-1:0]                  s1_col,
   input  logic [RW-1:0]                  s1_row,
   input  logic [CSW-1:0]                 s1_col_lo,
   input  logic [CSW-1:0]                 s1_col_hi,
   input  logic [RSW-1:0]                 s1_row_lo,
   input  logic [RSW-1:0]                 s1_row_hi,
   input  logic                           s1_fwd,
   input  logic [CSW-1:0]                 s1_fwd_data,
   input  logic [CSW-1:0]                 rd_data,
   output logic                           wr_en,
   output logic [CW-1:0]                  wr_addr,
   output logic [CSW-1:0]                 csum,
   output logic                           res_valid,
   output pcbb_pkg::box_type              res
);

   import pcbb_pkg::*;

   logic [RSW-1:0] row_sum_ff, row_sum_in, rsum;
   logic [CW-1:0]  first_col_ff, first_col_in, last_col_ff, last_col_in;
   logic [RW-1:0]  first_row_ff, first_row_in, last_row_ff, last_row_in;
   logic           col_seen_ff, col_seen_in, row_seen_ff, row_seen_in;
   logic [CSW-1:0] base;
   logic           col_hit, row_hit;
   logic [CW-1:0]  fc, lc, bw;
   logic [RW-1:0]  fr, lr, bh;

   function automatic logic [BOX_FIELD_W-1:0] fit_col(input logic [CW-1:0] v);
      logic [CW+BOX_FIELD_W-1:0] t;
      t = (CW+BOX_FIELD_W)'(v);
      return t[BOX_FIELD_W-1:0];
   endfunction

   function automatic logic [BOX_FIELD_W-1:0] fit_row(input logic [RW-1:0] v);
      logic [RW+BOX_FIELD_W-1:0] t;
      t = (RW+BOX_FIELD_W)'(v);
      return t[BOX_FIELD_W-1:0];
   endfunction

   assign base = s1_fwd ? s1_fwd_data : rd_data;
   assign csum = s1_ctl.first_row ? CSW'(s1_pixel) : base + CSW'(s1_pixel);
   assign rsum = row_sum_ff + RSW'(s1_pixel);

   assign col_hit = s1_ctl.last_row && (csum > s1_col_lo) && (csum < s1_col_hi);
   assign row_hit = s1_ctl.row_end && (rsum > s1_row_lo) && (rsum < s1_row_hi);

   assign wr_en   = s1_ctl.valid;
   assign wr_addr = s1_col;

   always_comb begin
      fc = (col_hit && !col_seen_ff) ? s1_col : first_col_ff;
      lc = col_hit ? s1_col : last_col_ff;
      fr = (row_hit && !row_seen_ff) ? s1_row : first_row_ff;
      lr = row_hit ? s1_row : last_row_ff;
      bw = lc - fc;
      bh = lr - fr;

      res_valid  = s1_ctl.valid && s1_ctl.frame_end;
      res.x      = fit_col(fc);
      res.y      = fit_row(fr);
      res.width  = fit_col(bw);
      res.height = fit_row(bh);
      res.valid  = (bw != '0) && (bh != '0);

      row_sum_in   = row_sum_ff;
      first_col_in = first_col_ff;
      last_col_in  = last_col_ff;
      first_row_in = first_row_ff;
      last_row_in  = last_row_ff;
      col_seen_in  = col_seen_ff;
      row_seen_in  = row_seen_ff;
      if (s1_ctl.valid) begin
         if (s1_ctl.frame_end) begin
            row_sum_in   = '0;
            first_col_in = '0;
            last_col_in  = '0;
            first_row_in = '0;
            last_row_in  = '0;
            col_seen_in  = 1'b0;
            row_seen_in  = 1'b0;
         end else begin
            row_sum_in   = s1_ctl.row_end ? '0 : rsum;
            first_col_in = fc;
            last_col_in  = lc;
            first_row_in = fr;
            last_row_in  = lr;
            col_seen_in  = col_seen_ff || col_hit;
            row_seen_in  = row_seen_ff || row_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff   <= '0;
         first_col_ff <= '0;
         last_col_ff  <= '0;
         first_row_ff <= '0;
         last_row_ff  <= '0;
         col_seen_ff  <= 1'b0;
         row_seen_ff  <= 1'b0;
      end else begin
         row_sum_ff   <= row_sum_in;
         first_col_ff <= first_col_in;
         last_col_ff  <= last_col_in;
         first_row_ff <= first_row_in;
         last_row_ff  <= last_row_in;
         col_seen_ff  <= col_seen_in;
         row_seen_ff  <= row_seen_in;
      end
   end

endmodule

[hw/rtl/projection_content_bounding_box.sv]
// ----------------------------------------------------------------------------
// projection_content_bounding_box
// Bounding box of image content from row and column projection profiles.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one 8-bit grey pixel per request, raster order, row by row.
//    A request is taken at a clock edge with req_valid high and req_stall low.
//  - rsp_* carries one box per frame, after its last pixel: first content
//    column and row, last-minus-first extents, and box_valid when both
//    extents are nonzero. The receiver holds it off with rsp_stall.
//  - csr_* writes frame_width (index 0) and frame_height (index 1); csr_ready
//    is always high. Write only while no frame is in progress.
//  - Throughput: one pixel per cycle. req_stall rises only for the last pixel
//    of a frame while the previous box is still in the pipe or held by the
//    receiver (tiny frames, or rsp_stall asserted).
//  - Box path: the frame's last pixel is taken into the front pipeline register,
//    the accumulate stage builds the box, and the output register captures it.
//  - Column sums live in a one-port-read, one-port-write RAM: read when the
//    pixel is taken, added and written back in the next cycle; a pixel of the
//    same column in the very next cycle (one-pixel rows) is forwarded.
//  - Reset: frame position, row sum and bounds clear, sizes return to 1024.
//    The column sum RAM needs no clearing: the first row of a frame writes it.
// ----------------------------------------------------------------------------
module projection_content_bounding_box #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel requests
   input  logic                               req_valid,
   input  logic [pcbb_pkg::PIXEL_W-1:0]       req_pixel,
   output logic                               req_stall,
   // box results
   output logic                               rsp_valid,
   output logic [pcbb_pkg::BOX_FIELD_W-1:0]   rsp_box_x,
   output logic [pcbb_pkg::BOX_FIELD_W-1:0]   rsp_box_y,
   output logic [pcbb_pkg::BOX_FIELD_W-1:0]   rsp_box_width,
   output logic [pcbb_pkg::BOX_FIELD_W-1:0]   rsp_box_height,
   output logic                               rsp_box_valid,
   input  logic                               rsp_stall,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcbb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pcbb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import pcbb_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CSW = $clog2(HIGH_FACTOR * MAX_HEIGHT + 1);
   localparam int RSW = $clog2(HIGH_FACTOR * MAX_WIDTH + 1);

   logic [CSR_DATA_W-1:0] frame_width_ff, frame_height_ff;

   logic                  rd_en, wr_en, out_busy, accept;
   logic [CW-1:0]         rd_addr, wr_addr;
   logic [CSW-1:0]        rd_data, csum;
   stage_ctl_type         s1_ctl;
   logic [PIXEL_W-1:0]    s1_pixel;
   logic [CW-1:0]         s1_col;
   logic [RW-1:0]         s1_row;
   logic [CSW-1:0]        s1_col_lo, s1_col_hi, s1_fwd_data;
   logic [RSW-1:0]        s1_row_lo, s1_row_hi;
   logic                  s1_fwd;
   logic                  res_valid;
   box_type               res;

   logic                  rsp_valid_ff, rsp_valid_in;
   box_type               rsp_box_ff;

   // ---- configuration registers -------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_SIZE_RESET;
         frame_height_ff <= FRAME_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---- position, clamp, RAM read -----------------------------------------
   // output register held by the receiver: a new box cannot land next edge
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign accept   = req_valid && !req_stall;

   pcbb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_pixel    (req_pixel),
      .req_stall    (req_stall),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .out_busy     (out_busy),
      .csum         (csum),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .s1_ctl       (s1_ctl),
      .s1_pixel     (s1_pixel),
      .s1_col       (s1_col),
      .s1_row       (s1_row),
      .s1_col_lo    (s1_col_lo),
      .s1_col_hi    (s1_col_hi),
      .s1_row_lo    (s1_row_lo),
      .s1_row_hi    (s1_row_hi),
      .s1_fwd       (s1_fwd),
      .s1_fwd_data  (s1_fwd_data)
   );

   // ---- column sum store --------------------------------------------------
   pcbb_ram #(
      .WIDTH (CSW),
      .DEPTH (MAX_WIDTH)
   ) u_col_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (csum),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- accumulate, test, track bounds ------------------------------------
   pcbb_accum #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .s1_ctl      (s1_ctl),
      .s1_pixel    (s1_pixel),
      .s1_col      (s1_col),
      .s1_row      (s1_row),
      .s1_col_lo   (s1_col_lo),
      .s1_col_hi   (s1_col_hi),
      .s1_row_lo   (s1_row_lo),
      .s1_row_hi   (s1_row_hi),
      .s1_fwd      (s1_fwd),
      .s1_fwd_data (s1_fwd_data),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .csum        (csum),
      .res_valid   (res_valid),
      .res         (res)
   );

   // ---- output register ---------------------------------------------------
   // the stall rule in front guarantees it is empty or draining when a box lands
   assign rsp_valid_in = res_valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_box_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_x      = rsp_box_ff.x;
   assign rsp_box_y      = rsp_box_ff.y;
   assign rsp_box_width  = rsp_box_ff.width;
   assign rsp_box_height = rsp_box_ff.height;
   assign rsp_box_valid  = rsp_box_ff.valid;

   // ---- assertions --------------------------------------------------------
   // a finished box never lands on one the receiver is still holding
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(rsp_valid_ff && rsp_stall))
      else $error("box produced while output register is held");

   // a box comes out of the accumulate stage in the cycle after its pixel is taken
   a_box_timing: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> $past(accept))
      else $error("box without a pixel taken the cycle before");

   // input is only held off while a box is in flight
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff || s1_ctl.valid))
      else $error("pixel stalled with no box pending");

endmodule
